[hdl/cpfd_pkg.sv]
// package for the controller poll frame decoder: types, constants, decode functions
`timescale 1ns / 1ps
package cpfd_pkg;

  localparam int PORT_COUNT_DEF      = 2;
  localparam int SLOTS_EACH_PORT_DEF = 4;
  localparam int FRAME_BYTES_DEF     = 34;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [3:0] K_NONE    = 4'd0;
  localparam logic [3:0] K_DIGITAL = 4'd1;
  localparam logic [3:0] K_APAD    = 4'd2;
  localparam logic [3:0] K_STICK   = 4'd3;
  localparam logic [3:0] K_DS2     = 4'd4;
  localparam logic [3:0] K_MOUSE   = 4'd5;
  localparam logic [3:0] K_TAP     = 4'd6;
  localparam logic [3:0] K_NEG     = 4'd7;
  localparam logic [3:0] K_GUN     = 4'd8;
  localparam logic [3:0] K_JOG     = 4'd9;
  localparam logic [3:0] K_KBD     = 4'd10;
  localparam logic [3:0] K_CFG     = 4'd11;
  localparam logic [3:0] K_UNK     = 4'd12;

  localparam logic [7:0] AXIS_CENTER = 8'h80;
  localparam logic [6:0] DEAD_ZONE_RESET = 7'd48;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_POLL = 1'b1;
  localparam logic REP_SLOT = 1'b0;
  localparam logic REP_ACTIVE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic       port_index;
    logic [7:0] byte_value;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic        report_type;
    logic [2:0]  slot_index;
    logic        present;
    logic [3:0]  device_kind;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic signed [31:0] mouse_x_total;
    logic signed [31:0] mouse_y_total;
    logic        last;
  } out_item_t;

  // commands handed from front to back
  typedef enum logic [1:0] {
    CMD_DECODE = 2'd0,  // decode one slot from the window
    CMD_CLEAR  = 2'd1,  // not issued by the front; the back end takes no action on it
    CMD_REPORT = 2'd2,  // emit four slot reports
    CMD_POLL   = 2'd3   // select the active slot
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic        port;
    logic [1:0]  sub;
    logic [7:0]  status;
    logic [7:0]  dtype;
    logic [2:0]  cap_lanes; // payload byte count minus one is not needed; 6 caps at six bytes, 0 means eight
    logic [63:0] payload;   // payload bytes, lane 0 first
  } cmd_t;

  function automatic logic [3:0] kind_of(input logic [7:0] t);
    logic [3:0] k;
    unique case (t[7:4])
      4'h1: k = K_MOUSE;
      4'h2: k = K_NEG;
      4'h3: k = K_GUN;
      4'h4: k = K_DIGITAL;
      4'h5: k = K_STICK;
      4'h6: k = K_GUN;
      4'h7: k = (t == 8'h73) ? K_APAD : K_DS2;
      4'h8: k = K_TAP;
      4'h9: k = K_KBD;
      4'hE: k = (t == 8'hE3) ? K_JOG : K_KBD;
      4'hF: k = (t == 8'hF3) ? K_CFG : K_NONE;
      default: k = K_UNK;
    endcase
    return k;
  endfunction

  function automatic logic is_analog(input logic [3:0] k);
    return (k == K_APAD) || (k == K_STICK) || (k == K_DS2);
  endfunction

  function automatic logic [7:0] axis_dev(input logic [7:0] a);
    return a[7] ? (a - AXIS_CENTER) : (AXIS_CENTER - a);
  endfunction

endpackage

[hdl/cpfd_front.sv]
// front end: frame byte tracking, header and window capture, command issue
`timescale 1ns / 1ps
module cpfd_front
  import cpfd_pkg::*;
#(
  parameter int PORT_COUNT  = PORT_COUNT_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_ready,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_ready
);

  localparam int PW = $clog2(FRAME_BYTES + 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   hdr_r, hdr_nxt;
  logic [63:0]   win_r, win_nxt;
  // up to two commands from one item: a decode, then a report; a poll issues only one
  cmd_t cmd_a_r, cmd_a_nxt, cmd_b_r, cmd_b_nxt;
  logic va_r, va_nxt, vb_r, vb_nxt;

  assign in_ready  = !va_r && !vb_r;
  assign cmd_valid = va_r || vb_r;
  assign cmd       = va_r ? cmd_a_r : cmd_b_r;

  logic [PW-1:0] rel;
  logic [2:0]    lane;
  logic          tap;
  logic          port_ok;
  logic          in_frame;

  assign rel      = pos_r - PW'(2);
  assign lane     = rel[2:0];
  assign tap      = (hdr_r == 16'h8000);
  assign port_ok  = (32'(in_item.port_index) < PORT_COUNT);
  assign in_frame = (32'(pos_r) < FRAME_BYTES);

  always_comb begin
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    win_nxt   = win_r;
    cmd_a_nxt = cmd_a_r;
    cmd_b_nxt = cmd_b_r;
    va_nxt    = va_r;
    vb_nxt    = vb_r;
    if (cmd_ready && cmd_valid) begin
      if (va_r) va_nxt = 1'b0;
      else vb_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      if (in_item.req_type == REQ_POLL) begin
        va_nxt = 1'b1;
        cmd_a_nxt = '0;
        cmd_a_nxt.op = CMD_POLL;
      end else if (port_ok) begin
        if (in_frame) begin
          if (pos_r == PW'(0)) begin
            hdr_nxt[7:0] = in_item.byte_value;
          end else if (pos_r == PW'(1)) begin
            hdr_nxt[15:8] = in_item.byte_value;
          end else begin
            win_nxt[lane*8 +: 8] = in_item.byte_value;
            if (lane == 3'd7) begin
              if (tap) begin
                va_nxt = 1'b1;
                cmd_a_nxt.op = CMD_DECODE;
                cmd_a_nxt.port = in_item.port_index;
                cmd_a_nxt.sub = rel[4:3];
                cmd_a_nxt.status = win_nxt[7:0];
                cmd_a_nxt.dtype = win_nxt[15:8];
                cmd_a_nxt.cap_lanes = 3'd6;
                cmd_a_nxt.payload = {16'h0, win_nxt[63:16]};
              end else if (pos_r == PW'(9)) begin
                va_nxt = 1'b1;
                cmd_a_nxt.op = CMD_DECODE;
                cmd_a_nxt.port = in_item.port_index;
                cmd_a_nxt.sub = 2'd0;
                cmd_a_nxt.status = hdr_r[7:0];
                cmd_a_nxt.dtype = hdr_r[15:8];
                cmd_a_nxt.cap_lanes = 3'd0; // zero means a full eight bytes
                cmd_a_nxt.payload = win_nxt;
              end
            end
          end
          pos_nxt = pos_r + PW'(1);
        end
        if (in_item.frame_last) begin
          pos_nxt = '0;
          vb_nxt = 1'b1;
          cmd_b_nxt = '0;
          cmd_b_nxt.op = CMD_REPORT;
          cmd_b_nxt.port = in_item.port_index;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hdr_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      hdr_r <= hdr_nxt;
      va_r  <= va_nxt;
      vb_r  <= vb_nxt;
    end
    win_r   <= win_nxt;
    cmd_a_r <= cmd_a_nxt;
    cmd_b_r <= cmd_b_nxt;
  end

endmodule

[hdl/cpfd_queue.sv]
// short command queue between the front and back parts
`timescale 1ns / 1ps
module cpfd_queue
  import cpfd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  input  cmd_t wr_data,
  output logic wr_ready,
  output logic rd_valid,
  output cmd_t rd_data,
  input  logic rd_ready
);

  localparam int AW = $clog2(DEPTH);

  cmd_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign wr_ready = (32'(cnt_r) < DEPTH);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rp_r];

  logic do_w, do_r;
  assign do_w = wr_valid && wr_ready;
  assign do_r = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_w) mem[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_w) wp_r <= (32'(wp_r) == DEPTH - 1) ? '0 : wp_r + AW'(1);
      if (do_r) rp_r <= (32'(rp_r) == DEPTH - 1) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(do_w) - (AW+1)'(do_r);
    end
  end

endmodule

[hdl/cpfd_back.sv]
// back end: slot state, decode, reports and active slot scan
`timescale 1ns / 1ps
module cpfd_back
  import cpfd_pkg::*;
#(
  parameter int PORT_COUNT = PORT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [6:0] dead_zone,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_ready,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_ready,
  output logic      busy
);

  localparam int SLOTS = PORT_COUNT * SLOTS_EACH_PORT_DEF;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_REP  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FALL = 4'b1000
  } st_t;

  st_t st_r, st_nxt;
  logic [SLOTS-1:0] pres_r;
  logic [3:0]  kind_r   [SLOTS];
  logic [15:0] bnow_r   [SLOTS];
  logic [15:0] bbef_r   [SLOTS];
  logic [31:0] axes_r   [SLOTS];
  logic [15:0] mdel_r   [SLOTS];
  logic [31:0] mx_r     [SLOTS];
  logic [31:0] my_r     [SLOTS];
  logic [3:0]  act_r;
  logic [2:0]  idx_r;     // slot under report or scan
  logic [1:0]  cnt_r;
  logic        ov_r;
  out_item_t   oi_r;

  assign out_valid = ov_r;
  assign out_item  = oi_r;
  assign busy      = (st_r != ST_IDLE) || ov_r;
  assign cmd_ready = (st_r == ST_IDLE) && (!ov_r || out_ready);

  // decode of the incoming command
  logic [3:0]  dk;
  logic [3:0]  pay;
  logic [15:0] raw;
  logic        absent;
  logic [2:0]  ds;
  logic [31:0] dx, dy;
  assign ds     = {cmd.port, cmd.sub};
  assign dk     = kind_of(cmd.dtype);
  assign absent = (cmd.status == 8'hFF) || (cmd.status == 8'h00 && cmd.dtype == 8'h00);
  always_comb begin
    logic [4:0] p;
    p = ({1'b0, cmd.dtype[3:0]} + 5'd1);
    if (cmd.cap_lanes == 3'd6) pay = (p > 5'd3) ? 4'd6 : {p[2:0], 1'b0};
    else pay = (p > 5'd4) ? 4'd8 : {p[2:0], 1'b0};
  end
  assign raw = cmd.payload[15:0];
  assign dx  = (pay >= 4'd4) ? {{24{cmd.payload[23]}}, cmd.payload[23:16]} : 32'd0;
  assign dy  = (pay >= 4'd4) ? {{24{cmd.payload[31]}}, cmd.payload[31:24]} : 32'd0;

  // activity test for the slot under scan
  logic has_in;
  always_comb begin
    logic [31:0] a;
    a = axes_r[idx_r];
    has_in = 1'b0;
    if (pres_r[idx_r]) begin
      if (bnow_r[idx_r] != 16'h0 && bnow_r[idx_r] != bbef_r[idx_r]) has_in = 1'b1;
      if (is_analog(kind_r[idx_r])) begin
        for (int i = 0; i < 4; i++)
          if (axis_dev(a[i*8 +: 8]) > {1'b0, dead_zone}) has_in = 1'b1;
      end
      if (kind_r[idx_r] == K_MOUSE && (mdel_r[idx_r] != 16'h0 || bnow_r[idx_r] != 16'h0))
        has_in = 1'b1;
    end
  end

  logic usable;
  assign usable = pres_r[idx_r] && kind_r[idx_r] != K_TAP;
  logic act_ok;
  assign act_ok = (32'(act_r) < SLOTS) && pres_r[act_r[2:0]] && kind_r[act_r[2:0]] != K_TAP;

  // output register free this cycle, and when the fallback search has its answer
  logic out_free;
  assign out_free = !ov_r || out_ready;
  logic fall_done;
  assign fall_done = act_ok || (!usable && 32'(idx_r) == SLOTS - 1);
  logic emit;
  assign emit = out_free && ((st_r == ST_REP) || (st_r == ST_FALL && fall_done));

  // active slot report, slot 0 and not present when nothing qualifies
  out_item_t act_item;
  always_comb begin
    act_item = '0;
    act_item.report_type = REP_ACTIVE;
    act_item.slot_index = act_ok ? act_r[2:0] : 3'd0;
    act_item.present = act_ok;
    act_item.right_x = AXIS_CENTER;
    act_item.right_y = AXIS_CENTER;
    act_item.left_x = AXIS_CENTER;
    act_item.left_y = AXIS_CENTER;
    act_item.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      act_r <= 4'd8;
      pres_r <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        kind_r[s] <= K_NONE;
        bnow_r[s] <= '0;
        bbef_r[s] <= '0;
        axes_r[s] <= 32'h80808080;
        mdel_r[s] <= '0;
        mx_r[s]   <= '0;
        my_r[s]   <= '0;
      end
    end else begin
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            unique case (cmd.op)
              CMD_DECODE: begin
                if (32'(ds) < SLOTS) begin
                  bbef_r[ds] <= bnow_r[ds];
                  if (absent) begin
                    kind_r[ds] <= K_NONE;
                    pres_r[ds] <= 1'b0;
                    bnow_r[ds] <= '0;
                  end else begin
                    kind_r[ds] <= dk;
                    pres_r[ds] <= 1'b1;
                    if (dk == K_DIGITAL || is_analog(dk)) begin
                      bnow_r[ds] <= ~raw;
                      axes_r[ds] <= (pay >= 4'd6 && is_analog(dk)) ?
                                    cmd.payload[47:16] : 32'h80808080;
                    end else if (dk == K_MOUSE) begin
                      bnow_r[ds] <= ~raw;
                      mdel_r[ds] <= {dy[7:0], dx[7:0]};
                      mx_r[ds] <= mx_r[ds] + dx;
                      my_r[ds] <= my_r[ds] + dy;
                    end else begin
                      bnow_r[ds] <= '0;
                    end
                  end
                end
                // direct device: clear the other sub-slots
                if (cmd.cap_lanes != 3'd6) begin
                  for (int i = 1; i < 4; i++) begin
                    bbef_r[{cmd.port, 2'(i)}] <= bnow_r[{cmd.port, 2'(i)}];
                    kind_r[{cmd.port, 2'(i)}] <= K_NONE;
                    pres_r[{cmd.port, 2'(i)}] <= 1'b0;
                    bnow_r[{cmd.port, 2'(i)}] <= '0;
                  end
                end
              end
              CMD_REPORT: begin
                idx_r <= {cmd.port, 2'd0};
                cnt_r <= 2'd0;
                st_r <= ST_REP;
              end
              CMD_POLL: begin
                idx_r <= 3'd0;
                st_r <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_REP: begin
          if (out_free) begin
            oi_r.report_type <= REP_SLOT;
            oi_r.slot_index <= idx_r;
            oi_r.present <= pres_r[idx_r];
            oi_r.device_kind <= kind_r[idx_r];
            oi_r.buttons <= bnow_r[idx_r];
            oi_r.right_x <= axes_r[idx_r][7:0];
            oi_r.right_y <= axes_r[idx_r][15:8];
            oi_r.left_x <= axes_r[idx_r][23:16];
            oi_r.left_y <= axes_r[idx_r][31:24];
            oi_r.mouse_x_total <= mx_r[idx_r];
            oi_r.mouse_y_total <= my_r[idx_r];
            oi_r.last <= (cnt_r == 2'd3);
            idx_r <= idx_r + 3'd1;
            cnt_r <= cnt_r + 2'd1;
            if (cnt_r == 2'd3) st_r <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (kind_r[idx_r] != K_TAP && has_in) act_r <= {1'b0, idx_r};
          if (32'(idx_r) == SLOTS - 1) begin
            idx_r <= 3'd0;
            st_r <= ST_FALL;
          end else begin
            idx_r <= idx_r + 3'd1;
          end
        end
        ST_FALL: begin
          if (fall_done) begin
            if (!act_ok) act_r <= 4'd8;
            if (out_free) begin
              oi_r <= act_item;
              st_r <= ST_IDLE;
            end
          end else if (usable) begin
            act_r <= {1'b0, idx_r};
          end else begin
            idx_r <= idx_r + 3'd1;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/controller_poll_frame_decoder.sv]
// top level of the controller poll frame decoder
`timescale 1ns / 1ps
// decode: a window command passes the front register and the queue, then updates its slot
// end of frame: the report command passes the queue, then slot reports one per cycle while popped
// poll done: the active report follows a scan of every slot and a fallback search for a usable slot
// throughput: one byte per cycle; input holds while its commands wait for the queue
// reset: synchronous active-low clears slot state, queue, counters and dead zone to 48
module controller_poll_frame_decoder
  import cpfd_pkg::*;
#(
  parameter int PORT_COUNT      = PORT_COUNT_DEF,
  parameter int FRAME_BYTES     = FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input queue side
  input  logic        in_push,
  input  in_item_t    in_data,
  output logic        in_full,
  // result queue side
  output logic        out_empty,
  output out_item_t   out_data,
  input  logic        out_pop,
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [1:0] ADDR_DEAD_ZONE = 2'd0;

  // dead zone register
  logic [6:0] dz_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_DEAD_ZONE) ? {25'h0, dz_r} : 32'h0;
  always_ff @(posedge clk) begin
    if (!rst_n) dz_r <= DEAD_ZONE_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_DEAD_ZONE)
      dz_r <= cfg_pwdata[6:0];
  end

  logic in_ready;
  assign in_full = !in_ready;

  // front to queue
  logic f_valid, f_ready;
  cmd_t f_cmd;
  cpfd_front #(.PORT_COUNT(PORT_COUNT), .FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk, .rst_n,
    .in_valid(in_push), .in_item(in_data), .in_ready,
    .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
  );

  // queue to back
  logic q_valid, q_ready;
  cmd_t q_cmd;
  cpfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_data(f_cmd), .wr_ready(f_ready),
    .rd_valid(q_valid), .rd_data(q_cmd), .rd_ready(q_ready)
  );

  logic o_valid, back_busy;
  cpfd_back #(.PORT_COUNT(PORT_COUNT)) u_back (
    .clk, .rst_n, .dead_zone(dz_r),
    .cmd_valid(q_valid), .cmd(q_cmd), .cmd_ready(q_ready),
    .out_valid(o_valid), .out_item(out_data), .out_ready(out_pop),
    .busy(back_busy)
  );
  assign out_empty = !o_valid;

  // results only ever come from back end work
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> back_busy) else $error("result shown while back end idle");
  // a popped result that was not last is followed by more work
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_data.last) |=> back_busy)
    else $error("report sequence cut short");
  // an active report is always the only result of its transaction
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.report_type == REP_ACTIVE) |-> out_data.last)
    else $error("active report not last");

endmodule
